FILE: rtl/core/framebuffer_raster_engine_assert.svh
// framebuffer_raster_engine_assert.svh: assertion macros for the raster engine checkers
// no dependencies; included by fbre_checker.sv
`ifndef FRAMEBUFFER_RASTER_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_RASTER_ENGINE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FBRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbre checker: property failed");

// consequent checked in the cycle after the antecedent
`define FBRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbre checker: property failed");

`endif

FILE: rtl/core/fbre_pkg.sv
// fbre_pkg: types and constants shared by the raster engine modules
// no dependencies
package fbre_pkg;

   localparam int COORD_W = 14;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [2:0] {
      OP_PIXEL       = 3'd0,
      OP_READ        = 3'd1,
      OP_LINE        = 3'd2,
      OP_RECT        = 3'd3,
      OP_FILL_RECT   = 3'd4,
      OP_CIRCLE      = 3'd5,
      OP_DISC        = 3'd6,
      OP_FILL_SCREEN = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      WS_IDLE,
      WS_SETUP,
      WS_MUL,
      WS_RUN
   } wlk_state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic signed [11:0] end_x;
      logic signed [11:0] end_y;
      logic [10:0]        width;
      logic [10:0]        height;
      logic [9:0]         radius;
      logic [15:0]        color;
   } req_type;

   typedef struct packed {
      logic [15:0] read_color;
      logic        read_inside;
   } rsp_type;

   // one pixel from the walker to the store pipeline
   typedef struct packed {
      logic      valid;
      logic      rd;
      logic      last;
      coord_type x;
      coord_type y;
   } pix_type;

   // midpoint circle decision updates
   localparam logic signed [15:0] CIRC_D_INIT   = 16'sd3;
   localparam logic signed [15:0] CIRC_DIAG_ADD = 16'sd10;
   localparam logic signed [15:0] CIRC_AXIS_ADD = 16'sd6;
   localparam int                 CIRC_SHIFT    = 2;

   // squaring steps before a filled circle scan
   localparam logic [1:0] MUL_R2   = 2'd0;
   localparam logic [1:0] MUL_XSQ  = 2'd1;
   localparam logic [1:0] MUL_LAST = 2'd2;

endpackage

FILE: rtl/core/fbre_ram.sv
// fbre_ram: generic single-write, single-read memory with registered read data
// no dependencies
module fbre_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 76800
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/fbre_walker.sv
// fbre_walker: per-command pixel sequencer (point, line, rectangles, circles, screen fill)
// depends on fbre_pkg; emits one pixel per cycle toward the frame store pipeline while in the run state
module fbre_walker #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fbre_pkg::req_type cmd,
   output fbre_pkg::pix_type pix
);

   localparam fbre_pkg::coord_type XMAX = fbre_pkg::coord_type'(SCREEN_WIDTH - 1);
   localparam fbre_pkg::coord_type YMAX = fbre_pkg::coord_type'(SCREEN_HEIGHT - 1);

   fbre_pkg::wlk_state_type state_ff, state_in;
   fbre_pkg::op_type        op_ff, op_in;
   fbre_pkg::coord_type     ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic [10:0]             w_ff, w_in, h_ff, h_in;
   logic [9:0]              r_ff, r_in;
   fbre_pkg::coord_type     x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   fbre_pkg::coord_type     xr_ff, xr_in, yb_ff, yb_in;
   fbre_pkg::coord_type     cx_ff, cx_in, cy_ff, cy_in;
   fbre_pkg::coord_type     dx_ff, dx_in, dy_ff, dy_in;
   logic                    stx_ff, stx_in, sty_ff, sty_in;
   logic signed [15:0]      err_ff, err_in;
   fbre_pkg::coord_type     ca_ff, ca_in, cb_ff, cb_in;
   logic [2:0]              oct_ff, oct_in;
   logic signed [15:0]      cd_ff, cd_in;
   logic [20:0]             s_ff, s_in;
   logic [19:0]             jj_ff, jj_in, xsq_ff, xsq_in, r2_ff, r2_in;
   logic [1:0]              mstep_ff, mstep_in;
   fbre_pkg::pix_type       pix_ff, pix_in;

   // setup geometry
   fbre_pkg::coord_type xr_c, yb_c, bx0_c, bx1_c, by0_c, by1_c;
   fbre_pkg::coord_type pos_r_c, neg_r_c, ddx_c, ddy_c, adx_c, ady_c;
   logic                box_empty_c;

   // datapath temporaries
   logic                setup_empty, run_last;
   logic signed [16:0]  e2;
   logic                step_x, step_y;
   fbre_pkg::coord_type an, bn, mabs;
   logic signed [15:0]  dn;
   logic [9:0]          mop;
   logic [19:0]         prod;
   logic [19:0]         jj_next;
   logic                row_end, edge_row;

   // first x of a scan row: outline side rows start at the left edge
   function automatic fbre_pkg::coord_type row_start(
      input logic                outline,
      input fbre_pkg::coord_type yy,
      input fbre_pkg::coord_type top,
      input fbre_pkg::coord_type bot,
      input fbre_pkg::coord_type left,
      input fbre_pkg::coord_type first
   );
      fbre_pkg::coord_type res;
      res = (outline && yy != top && yy != bot) ? left : first;
      return res;
   endfunction

   // clipped box for rectangles, offset box for filled circles
   always_comb begin
      xr_c    = ax_ff + fbre_pkg::coord_type'({3'b000, w_ff}) - fbre_pkg::coord_type'(1);
      yb_c    = ay_ff + fbre_pkg::coord_type'({3'b000, h_ff}) - fbre_pkg::coord_type'(1);
      pos_r_c = fbre_pkg::coord_type'({4'b0000, r_ff});
      neg_r_c = -pos_r_c;
      ddx_c   = bx_ff - ax_ff;
      ddy_c   = by_ff - ay_ff;
      adx_c   = (ddx_c < 0) ? -ddx_c : ddx_c;
      ady_c   = (ddy_c < 0) ? -ddy_c : ddy_c;
      bx0_c   = '0;
      bx1_c   = XMAX;
      by0_c   = '0;
      by1_c   = YMAX;
      box_empty_c = 1'b0;
      if (op_ff == fbre_pkg::OP_DISC) begin
         bx0_c = (neg_r_c < -ax_ff) ? -ax_ff : neg_r_c;
         bx1_c = (pos_r_c > XMAX - ax_ff) ? XMAX - ax_ff : pos_r_c;
         by0_c = (neg_r_c < -ay_ff) ? -ay_ff : neg_r_c;
         by1_c = (pos_r_c > YMAX - ay_ff) ? YMAX - ay_ff : pos_r_c;
         box_empty_c = (bx0_c > bx1_c) || (by0_c > by1_c);
      end else if (op_ff != fbre_pkg::OP_FILL_SCREEN) begin
         bx0_c = (ax_ff < 0) ? '0 : ax_ff;
         bx1_c = (xr_c > XMAX) ? XMAX : xr_c;
         by0_c = (ay_ff < 0) ? '0 : ay_ff;
         by1_c = (yb_c > YMAX) ? YMAX : yb_c;
         box_empty_c = (w_ff == '0) || (h_ff == '0) || (bx0_c > bx1_c) || (by0_c > by1_c);
      end
   end

   // shared squaring unit for the filled circle setup
   always_comb begin
      unique case (mstep_ff)
         fbre_pkg::MUL_R2:  mabs = pos_r_c;
         fbre_pkg::MUL_XSQ: mabs = (x0_ff < 0) ? -x0_ff : x0_ff;
         default:           mabs = (y0_ff < 0) ? -y0_ff : y0_ff;
      endcase
      mop  = mabs[9:0];
      prod = 20'(mop) * 20'(mop);
   end

   // register updates per state and opcode
   always_comb begin
      op_in = op_ff;  ax_in = ax_ff;  ay_in = ay_ff;  bx_in = bx_ff;  by_in = by_ff;
      w_in = w_ff;  h_in = h_ff;  r_in = r_ff;
      x0_in = x0_ff;  x1_in = x1_ff;  y0_in = y0_ff;  y1_in = y1_ff;
      xr_in = xr_ff;  yb_in = yb_ff;  cx_in = cx_ff;  cy_in = cy_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  stx_in = stx_ff;  sty_in = sty_ff;  err_in = err_ff;
      ca_in = ca_ff;  cb_in = cb_ff;  oct_in = oct_ff;  cd_in = cd_ff;
      s_in = s_ff;  jj_in = jj_ff;  xsq_in = xsq_ff;  r2_in = r2_ff;  mstep_in = mstep_ff;
      pix_in = '0;
      setup_empty = 1'b0;
      run_last = 1'b0;
      e2 = {err_ff, 1'b0};
      step_x = 1'b0;
      step_y = 1'b0;
      an = ca_ff + fbre_pkg::coord_type'(1);
      bn = cb_ff;
      dn = cd_ff;
      jj_next = jj_ff;
      row_end = 1'b0;
      edge_row = 1'b1;
      unique case (state_ff)
         fbre_pkg::WS_IDLE: begin
            if (start) begin
               op_in = fbre_pkg::op_type'(cmd.opcode);
               ax_in = fbre_pkg::coord_type'(cmd.x);
               ay_in = fbre_pkg::coord_type'(cmd.y);
               bx_in = fbre_pkg::coord_type'(cmd.end_x);
               by_in = fbre_pkg::coord_type'(cmd.end_y);
               w_in  = cmd.width;
               h_in  = cmd.height;
               r_in  = cmd.radius;
            end
         end
         fbre_pkg::WS_SETUP: begin
            x0_in = bx0_c;  x1_in = bx1_c;  y0_in = by0_c;  y1_in = by1_c;
            xr_in = xr_c;   yb_in = yb_c;
            cy_in = by0_c;
            cx_in = row_start(op_ff == fbre_pkg::OP_RECT, by0_c, ay_ff, yb_c, ax_ff, bx0_c);
            // line walk start
            dx_in  = adx_c;
            dy_in  = -ady_c;
            stx_in = ax_ff < bx_ff;
            sty_in = ay_ff < by_ff;
            err_in = 16'(adx_c) - 16'(ady_c);
            // circle walk start
            ca_in  = '0;
            cb_in  = pos_r_c;
            oct_in = '0;
            cd_in  = fbre_pkg::CIRC_D_INIT - $signed({5'b00000, r_ff, 1'b0});
            mstep_in = fbre_pkg::MUL_R2;
            setup_empty = box_empty_c && (op_ff == fbre_pkg::OP_RECT ||
               op_ff == fbre_pkg::OP_FILL_RECT || op_ff == fbre_pkg::OP_DISC);
            pix_in.last = setup_empty;
         end
         fbre_pkg::WS_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            unique case (mstep_ff)
               fbre_pkg::MUL_R2:  r2_in = prod;
               fbre_pkg::MUL_XSQ: xsq_in = prod;
               default: begin
                  jj_in = prod;
                  s_in  = {1'b0, xsq_ff} + {1'b0, prod};
               end
            endcase
         end
         fbre_pkg::WS_RUN: begin
            unique case (op_ff)
               fbre_pkg::OP_PIXEL, fbre_pkg::OP_READ: begin
                  run_last = 1'b1;
                  pix_in = '{valid: 1'b1, rd: op_ff == fbre_pkg::OP_READ, last: 1'b1,
                             x: ax_ff, y: ay_ff};
               end
               fbre_pkg::OP_LINE: begin
                  run_last = (ax_ff == bx_ff) && (ay_ff == by_ff);
                  pix_in = '{valid: 1'b1, rd: 1'b0, last: run_last, x: ax_ff, y: ay_ff};
                  step_x = e2 >= 17'(dy_ff);
                  step_y = e2 <= 17'(dx_ff);
                  err_in = err_ff + (step_x ? 16'(dy_ff) : 16'sd0)
                                  + (step_y ? 16'(dx_ff) : 16'sd0);
                  if (step_x) begin
                     ax_in = stx_ff ? ax_ff + fbre_pkg::coord_type'(1)
                                    : ax_ff - fbre_pkg::coord_type'(1);
                  end
                  if (step_y) begin
                     ay_in = sty_ff ? ay_ff + fbre_pkg::coord_type'(1)
                                    : ay_ff - fbre_pkg::coord_type'(1);
                  end
               end
               fbre_pkg::OP_CIRCLE: begin
                  // eight symmetric points, then one midpoint step
                  pix_in.valid = 1'b1;
                  unique case (oct_ff)
                     3'd0: begin pix_in.x = ax_ff + ca_ff; pix_in.y = ay_ff + cb_ff; end
                     3'd1: begin pix_in.x = ax_ff - ca_ff; pix_in.y = ay_ff + cb_ff; end
                     3'd2: begin pix_in.x = ax_ff + ca_ff; pix_in.y = ay_ff - cb_ff; end
                     3'd3: begin pix_in.x = ax_ff - ca_ff; pix_in.y = ay_ff - cb_ff; end
                     3'd4: begin pix_in.x = ax_ff + cb_ff; pix_in.y = ay_ff + ca_ff; end
                     3'd5: begin pix_in.x = ax_ff - cb_ff; pix_in.y = ay_ff + ca_ff; end
                     3'd6: begin pix_in.x = ax_ff + cb_ff; pix_in.y = ay_ff - ca_ff; end
                     default: begin pix_in.x = ax_ff - cb_ff; pix_in.y = ay_ff - ca_ff; end
                  endcase
                  if (cd_ff > 16'sd0) begin
                     bn = cb_ff - fbre_pkg::coord_type'(1);
                     dn = cd_ff + (16'(an - bn) <<< fbre_pkg::CIRC_SHIFT)
                          + fbre_pkg::CIRC_DIAG_ADD;
                  end else begin
                     dn = cd_ff + (16'(an) <<< fbre_pkg::CIRC_SHIFT)
                          + fbre_pkg::CIRC_AXIS_ADD;
                  end
                  oct_in = oct_ff + 3'd1;
                  if (oct_ff == 3'd7) begin
                     ca_in = an;
                     cb_in = bn;
                     cd_in = dn;
                     run_last = bn < an;
                  end
                  pix_in.last = run_last;
               end
               fbre_pkg::OP_DISC: begin
                  // offsets (cx, cy) walk the clipped box, sum of squares kept incrementally
                  row_end  = cx_ff == x1_ff;
                  run_last = row_end && (cy_ff == y1_ff);
                  pix_in = '{valid: s_ff <= {1'b0, r2_ff}, rd: 1'b0, last: run_last,
                             x: ax_ff + cx_ff, y: ay_ff + cy_ff};
                  jj_next = 20'($signed({3'b000, jj_ff}) + 23'($signed({cy_ff, 1'b1})));
                  if (!row_end) begin
                     cx_in = cx_ff + fbre_pkg::coord_type'(1);
                     s_in  = 21'($signed({2'b00, s_ff}) + 23'($signed({cx_ff, 1'b1})));
                  end else begin
                     cx_in = x0_ff;
                     cy_in = cy_ff + fbre_pkg::coord_type'(1);
                     jj_in = jj_next;
                     s_in  = {1'b0, xsq_ff} + {1'b0, jj_next};
                  end
               end
               default: begin
                  // rectangle outline, filled rectangle, screen fill
                  edge_row = (op_ff != fbre_pkg::OP_RECT) || cy_ff == ay_ff || cy_ff == yb_ff;
                  row_end  = edge_row ? (cx_ff == x1_ff) : (cx_ff == xr_ff);
                  run_last = row_end && (cy_ff == y1_ff);
                  pix_in = '{valid: 1'b1, rd: 1'b0, last: run_last, x: cx_ff, y: cy_ff};
                  if (!row_end) begin
                     cx_in = edge_row ? cx_ff + fbre_pkg::coord_type'(1) : xr_ff;
                  end else begin
                     cy_in = cy_ff + fbre_pkg::coord_type'(1);
                     cx_in = row_start(op_ff == fbre_pkg::OP_RECT,
                                       cy_ff + fbre_pkg::coord_type'(1),
                                       ay_ff, yb_ff, ax_ff, x0_ff);
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbre_pkg::WS_IDLE: begin
            if (start) state_in = fbre_pkg::WS_SETUP;
         end
         fbre_pkg::WS_SETUP: begin
            if (setup_empty) begin
               state_in = fbre_pkg::WS_IDLE;
            end else if (op_ff == fbre_pkg::OP_DISC) begin
               state_in = fbre_pkg::WS_MUL;
            end else begin
               state_in = fbre_pkg::WS_RUN;
            end
         end
         fbre_pkg::WS_MUL: begin
            if (mstep_ff == fbre_pkg::MUL_LAST) state_in = fbre_pkg::WS_RUN;
         end
         fbre_pkg::WS_RUN: begin
            if (run_last) state_in = fbre_pkg::WS_IDLE;
         end
         default: state_in = fbre_pkg::WS_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbre_pkg::WS_IDLE;
         pix_ff.valid <= 1'b0;
         pix_ff.last  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pix_ff.valid <= pix_in.valid;
         pix_ff.last  <= pix_in.last;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;  ax_ff <= ax_in;  ay_ff <= ay_in;  bx_ff <= bx_in;  by_ff <= by_in;
      w_ff <= w_in;  h_ff <= h_in;  r_ff <= r_in;
      x0_ff <= x0_in;  x1_ff <= x1_in;  y0_ff <= y0_in;  y1_ff <= y1_in;
      xr_ff <= xr_in;  yb_ff <= yb_in;  cx_ff <= cx_in;  cy_ff <= cy_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  stx_ff <= stx_in;  sty_ff <= sty_in;
      err_ff <= err_in;
      ca_ff <= ca_in;  cb_ff <= cb_in;  oct_ff <= oct_in;  cd_ff <= cd_in;
      s_ff <= s_in;  jj_ff <= jj_in;  xsq_ff <= xsq_in;  r2_ff <= r2_in;
      mstep_ff <= mstep_in;
      pix_ff.rd <= pix_in.rd;
      pix_ff.x  <= pix_in.x;
      pix_ff.y  <= pix_in.y;
   end

   assign pix = pix_ff;

endmodule

FILE: rtl/core/framebuffer_raster_engine.sv
// framebuffer_raster_engine: top level; uses fbre_pkg, fbre_walker and fbre_ram
// path: a command passes the walker setup, for a filled circle the squaring steps, then the
//   walk (8 pixels per circle step), the store and result stages and the response register
// throughput: one pixel per cycle through the frame store write port, one command at a time
// reset: synchronous; the frame store is then cleared to zero, all SCREEN_WIDTH*SCREEN_HEIGHT
//   words (76800 by default), while req_ready stays low
module framebuffer_raster_engine #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fbre_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fbre_pkg::rsp_type rsp
);

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   fbre_pkg::pix_type pix;
   logic              start;
   logic              on_screen;
   logic [ADDR_W-1:0] addr_in;
   logic [15:0]       ram_rd_data;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [15:0]       ram_wr_data;
   fbre_pkg::rsp_type new_rsp;
   logic              slot_free;

   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              busy_ff, busy_in;
   logic [15:0]       color_ff, color_in;
   logic              b_wr_ff, b_rd_ff, b_last_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic              c_rd_ff, c_last_ff;
   logic              rsp_valid_ff, rsp_valid_in, hold_valid_ff, hold_valid_in;
   fbre_pkg::rsp_type rsp_ff, rsp_in, hold_ff, hold_in;

   assign req_ready = !clr_ff && !busy_ff && !hold_valid_ff;
   assign start     = req_valid && req_ready;

   fbre_walker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req),
      .pix   (pix)
   );

   // clip and row-major address
   always_comb begin
      on_screen = (pix.x >= 0) && (pix.x < fbre_pkg::coord_type'(SCREEN_WIDTH)) &&
                  (pix.y >= 0) && (pix.y < fbre_pkg::coord_type'(SCREEN_HEIGHT));
      addr_in = ADDR_W'(ADDR_W'(pix.y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pix.x));
   end

   // store port: clearing pass, then pixel writes
   assign ram_wr_en   = clr_ff || b_wr_ff;
   assign ram_wr_addr = clr_ff ? clr_addr_ff : b_addr_ff;
   assign ram_wr_data = clr_ff ? 16'h0000 : color_ff;

   fbre_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (b_rd_ff),
      .rd_addr (b_addr_ff),
      .rd_data (ram_rd_data)
   );

   // clearing pass and command bookkeeping
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) clr_in = 1'b0;
      end
      busy_in  = start ? 1'b1 : (c_last_ff ? 1'b0 : busy_ff);
      color_in = start ? req.color : color_ff;
   end

   // result transaction: output register with one holding slot behind it
   always_comb begin
      new_rsp.read_color  = c_rd_ff ? ram_rd_data : 16'h0000;
      new_rsp.read_inside = c_rd_ff;
      slot_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (slot_free) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = hold_ff;
            hold_valid_in = c_last_ff;
            hold_in       = new_rsp;
         end else begin
            rsp_valid_in = c_last_ff;
            rsp_in       = new_rsp;
         end
      end else if (c_last_ff) begin
         hold_valid_in = 1'b1;
         hold_in       = new_rsp;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= 1'b1;
         clr_addr_ff   <= '0;
         busy_ff       <= 1'b0;
         b_wr_ff       <= 1'b0;
         b_rd_ff       <= 1'b0;
         b_last_ff     <= 1'b0;
         c_rd_ff       <= 1'b0;
         c_last_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         clr_addr_ff   <= clr_addr_in;
         busy_ff       <= busy_in;
         b_wr_ff       <= pix.valid && !pix.rd && on_screen;
         b_rd_ff       <= pix.valid && pix.rd && on_screen;
         b_last_ff     <= pix.last;
         c_rd_ff       <= b_rd_ff;
         c_last_ff     <= b_last_ff;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      color_ff  <= color_in;
      b_addr_ff <= addr_in;
      rsp_ff    <= rsp_in;
      hold_ff   <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/core/fbre_checker.sv
// fbre_checker: port-level assertions for framebuffer_raster_engine, bound to the top level
// depends on fbre_pkg and framebuffer_raster_engine_assert.svh
`include "framebuffer_raster_engine_assert.svh"

module fbre_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input fbre_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fbre_pkg::rsp_type rsp
);

   // a stalled result transaction keeps its payload
   `FBRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

   // only an inside read carries a colour
   `FBRE_ASSERT_NOW(a_rsp_black, clock, reset, rsp_valid && !rsp.read_inside, rsp.read_color == 16'h0000)

   // one command in flight: no acceptance right after an acceptance
   `FBRE_ASSERT_NEXT(a_one_cmd, clock, reset, req_valid && req_ready, !req_ready)

   // the store clear keeps the request side closed right after reset
   `FBRE_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), !req_ready)

endmodule

bind framebuffer_raster_engine fbre_checker u_checker (.*);
